// ===== rtl/miller_rabin_prime_test_64_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the primality tester
// Shorthand for clocked implications with reset gating.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_64_TOP_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_64_TOP_MACROS_SVH

// same-cycle implication
`define MRPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define MRPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Primality tester package
// Word width, witness table and shared helpers.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int WORD_BITS     = 64;
  localparam int NUM_WITNESSES = 9;
  localparam int CNT_BITS      = $clog2(WORD_BITS);
  localparam int WIT_BITS      = $clog2(NUM_WITNESSES + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [WIT_BITS-1:0]  wit_idx_t;

  function automatic logic [4:0] witness(input wit_idx_t idx);
    logic [4:0] w;
    case (idx)
      WIT_BITS'(0): w = 5'd2;
      WIT_BITS'(1): w = 5'd3;
      WIT_BITS'(2): w = 5'd5;
      WIT_BITS'(3): w = 5'd7;
      WIT_BITS'(4): w = 5'd11;
      WIT_BITS'(5): w = 5'd13;
      WIT_BITS'(6): w = 5'd17;
      WIT_BITS'(7): w = 5'd19;
      default:      w = 5'd23;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mrpt_mulmod.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a*b mod m, scanning b from the top bit, double then add per bit.
// ----------------------------------------------------------------------------
module mrpt_mulmod
  import mrpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t a,
  input  word_t b,
  input  word_t m,
  output logic  done,
  output word_t p
);

  logic  run;
  logic  phase;
  cnt_t  cnt;
  word_t bsh;
  word_t opa;
  word_t opm;

  function automatic word_t add_mod(input word_t x, input word_t y, input word_t md);
    logic [WORD_BITS:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= {1'b0, md}) begin
      sum = sum - {1'b0, md};
    end
    return sum[WORD_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
        p     <= '0;
        bsh   <= b;
        opa   <= a;
        opm   <= m;
      end else if (run) begin
        if (!phase) begin
          p     <= add_mod(p, p, opm);
          phase <= 1'b1;
        end else begin
          if (bsh[WORD_BITS-1]) begin
            p <= add_mod(p, opa, opm);
          end
          bsh   <= {bsh[WORD_BITS-2:0], 1'b0};
          cnt   <= cnt + 1'b1;
          phase <= 1'b0;
          if (cnt == CNT_BITS'(WORD_BITS - 1)) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/miller_rabin_prime_test_64_top.sv =====
// Flow: trivial candidates are decided in CHECK; others run a bit-serial mod 3 check and, if
//   not rejected there, go through up to nine witnesses of up to 126 multiplies each.
// Throughput: one candidate at a time; the next is taken once the result is queued.
// Reset: synchronous, active high; clears control and the output valid.
// ----------------------------------------------------------------------------
// Miller-Rabin primality tester, top level
// Trial checks by 2 and 3, then deterministic witnesses over a serial multiplier.
// ----------------------------------------------------------------------------
`include "miller_rabin_prime_test_64_top_macros.svh"

module miller_rabin_prime_test_64_top
  import mrpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] candidate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] prime_flag, [7:1] zero
);

  typedef enum logic [3:0] {
    IDLE, CHECK, MOD3, STRIP, WIT, PBIT, PMUL_A, PMUL_B, CHK1, SQ, SQW, DONE
  } state_t;

  state_t   state;
  word_t    n;
  word_t    nm1;
  word_t    d;
  word_t    e;
  word_t    sh;
  word_t    acc;
  word_t    base;
  cnt_t     s;
  cnt_t     r;
  cnt_t     cnt;
  logic [1:0] r3;
  wit_idx_t wi;
  logic     flag;
  logic     out_flag;
  logic     mul_start;
  word_t    mul_a;
  word_t    mul_b;
  logic     mul_done;
  word_t    mul_p;

  function automatic logic [1:0] mod3_step(input logic [1:0] rr, input logic bit_in);
    logic [1:0] nx;
    case ({rr, bit_in})
      3'b000:  nx = 2'd0;
      3'b001:  nx = 2'd1;
      3'b010:  nx = 2'd2;
      3'b011:  nx = 2'd0;
      3'b100:  nx = 2'd1;
      3'b101:  nx = 2'd2;
      default: nx = 2'd0;
    endcase
    return nx;
  endfunction

  mrpt_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (n),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign s_axis_tready = (state == IDLE);
  assign m_axis_tdata  = {7'd0, out_flag};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      m_axis_tvalid <= 1'b0;
      mul_start     <= 1'b0;
    end else begin
      mul_start <= (state == PBIT && e != '0) || (state == PMUL_A && mul_done) ||
                   (state == SQ && r < s);
      m_axis_tvalid <= (state == DONE) || (m_axis_tvalid && !m_axis_tready);
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            n     <= s_axis_tdata[WORD_BITS-1:0];
            state <= CHECK;
          end
        end
        CHECK: begin
          nm1 <= n - 1'b1;
          if (n < WORD_BITS'(2)) begin
            flag  <= 1'b0;
            state <= DONE;
          end else if (n == WORD_BITS'(2) || n == WORD_BITS'(3)) begin
            flag  <= 1'b1;
            state <= DONE;
          end else if (!n[0]) begin
            flag  <= 1'b0;
            state <= DONE;
          end else begin
            sh    <= n;
            r3    <= 2'd0;
            cnt   <= '0;
            state <= MOD3;
          end
        end
        MOD3: begin
          r3  <= mod3_step(r3, sh[WORD_BITS-1]);
          sh  <= {sh[WORD_BITS-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_BITS'(WORD_BITS - 1)) begin
            if (mod3_step(r3, sh[WORD_BITS-1]) == 2'd0) begin
              flag  <= 1'b0;
              state <= DONE;
            end else begin
              d     <= nm1;
              s     <= '0;
              state <= STRIP;
            end
          end
        end
        STRIP: begin
          if (!d[0]) begin
            d <= {1'b0, d[WORD_BITS-1:1]};
            s <= s + 1'b1;
          end else begin
            wi    <= '0;
            state <= WIT;
          end
        end
        WIT: begin
          if (wi == WIT_BITS'(NUM_WITNESSES) ||
              n <= WORD_BITS'(witness(wi))) begin
            flag  <= 1'b1;
            state <= DONE;
          end else begin
            base  <= WORD_BITS'(witness(wi));
            acc   <= WORD_BITS'(1);
            e     <= d;
            state <= PBIT;
          end
        end
        PBIT: begin
          if (e == '0) begin
            state <= CHK1;
          end else if (e[0]) begin
            mul_a <= acc;
            mul_b <= base;
            state <= PMUL_A;
          end else begin
            mul_a <= base;
            mul_b <= base;
            state <= PMUL_B;
          end
        end
        PMUL_A: begin
          if (mul_done) begin
            acc   <= mul_p;
            mul_a <= base;
            mul_b <= base;
            state <= PMUL_B;
          end
        end
        PMUL_B: begin
          if (mul_done) begin
            base  <= mul_p;
            e     <= {1'b0, e[WORD_BITS-1:1]};
            state <= PBIT;
          end
        end
        CHK1: begin
          if (acc == WORD_BITS'(1) || acc == nm1) begin
            wi    <= wi + 1'b1;
            state <= WIT;
          end else begin
            r     <= CNT_BITS'(1);
            state <= SQ;
          end
        end
        SQ: begin
          if (r >= s) begin
            flag  <= 1'b0;
            state <= DONE;
          end else begin
            mul_a <= acc;
            mul_b <= acc;
            state <= SQW;
          end
        end
        SQW: begin
          if (mul_done) begin
            acc <= mul_p;
            if (mul_p == nm1) begin
              wi    <= wi + 1'b1;
              state <= WIT;
            end else begin
              r     <= r + 1'b1;
              state <= SQ;
            end
          end
        end
        DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_flag <= flag;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `MRPT_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, state == CHECK)
  `MRPT_ASSERT_NEXT(a_mul_not_instant, mul_start, !mul_done)
  `MRPT_ASSERT_NOW(a_mul_only_when_waiting, mul_done,
    state == PMUL_A || state == PMUL_B || state == SQW)

endmodule
